// ===== sv/bal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list package
// Shared types, codes and sizes for the bounded array list block.
// ----------------------------------------------------------------------------
package bal_pkg;

  // List size and field widths. The port fields fix these.
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned COUNT_W     = IDX_W + 1;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned WORD_WIDTH  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_REM_FIRST = 3'd1,
    OP_REM_LAST  = 3'd2,
    OP_REM_AT    = 3'd3,
    OP_GET_FIRST = 3'd4,
    OP_GET_LAST  = 3'd5,
    OP_GET_AT    = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // One decoded request as it sits in the queue.
  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   position;
    logic [FIELD_W-1:0] value;
  } req_t;

endpackage
`default_nettype wire

// ===== sv/bal_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list front end
// Accepts request transactions, decodes the function code and queues them.
// ----------------------------------------------------------------------------
module bal_front
  import bal_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_valid_i,
  output logic                         s_ready_o,
  input  wire logic [FUNC_W-1:0]       s_func_i,
  input  wire logic [IDX_W-1:0]        s_position_i,
  input  wire logic [FIELD_W-1:0]      s_value_i,
  output logic                         q_valid_o,
  input  wire logic                    q_ready_i,
  output req_t                         q_req_o
);

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  req_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  req_t              dec_req;
  logic              push, pop;

  always_comb begin
    dec_req.position = s_position_i;
    dec_req.value    = s_value_i;
    case (s_func_i)
      OP_APPEND:    dec_req.op = OP_APPEND;
      OP_REM_FIRST: dec_req.op = OP_REM_FIRST;
      OP_REM_LAST:  dec_req.op = OP_REM_LAST;
      OP_REM_AT:    dec_req.op = OP_REM_AT;
      OP_GET_FIRST: dec_req.op = OP_GET_FIRST;
      OP_GET_LAST:  dec_req.op = OP_GET_LAST;
      OP_GET_AT:    dec_req.op = OP_GET_AT;
      default:      dec_req.op = OP_NOP;
    endcase
  end

  assign s_ready_o = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign q_valid_o = (fill_q != '0);
  assign q_req_o   = mem_q[rd_ptr_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec_req;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bal_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list back end
// Holds the entries and the count, executes one request per cycle while the
// output register is free or being read, and keeps each result there until taken.
// ----------------------------------------------------------------------------
module bal_back
  import bal_pkg::*;
#(
  parameter int unsigned WORD_W = WORD_WIDTH  // 1 to 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CAP_W-1:0]     cfg_wdata_i,
  input  wire logic                 q_valid_i,
  output logic                      q_ready_o,
  input  req_t                      q_req_i,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output status_e                   m_status_o,
  output logic [FIELD_W-1:0]        m_read_word_o,
  output logic [COUNT_W-1:0]        m_entry_count_o
);

  logic [WORD_W-1:0]  entries_q [DEPTH];
  logic [COUNT_W-1:0] count_q, count_d;
  logic [CAP_W-1:0]   capacity_q;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [FIELD_W-1:0] word_q, word_d;

  logic [COUNT_W-1:0] cap_eff;
  logic [COUNT_W-1:0] count_m1;
  logic               is_empty, pos_ok;
  logic [IDX_W-1:0]   rd_idx, shift_base;
  logic [WORD_W-1:0]  rd_word;
  logic               do_append, do_shift, exec;

  assign q_ready_o = !out_valid_q || m_ready_i;
  assign exec      = q_valid_i && q_ready_o;

  // Capacity above the array size saturates at the array size.
  assign cap_eff  = ({1'b0, capacity_q} > {1'b0, DEPTH_CNT}) ? DEPTH_CNT
                                                                : COUNT_W'(capacity_q);
  assign count_m1 = count_q - COUNT_W'(1);
  assign is_empty = (count_q == '0);
  assign pos_ok   = ({1'b0, q_req_i.position} < count_q);
  assign rd_word  = entries_q[rd_idx];

  always_comb begin
    count_d    = count_q;
    status_d   = ST_DONE;
    word_d     = '0;
    rd_idx     = '0;
    shift_base = '0;
    do_append  = 1'b0;
    do_shift   = 1'b0;
    case (q_req_i.op)
      OP_APPEND: begin
        if (count_q >= cap_eff) begin
          status_d = ST_FULL;
        end else begin
          do_append = 1'b1;
          count_d   = count_q + COUNT_W'(1);
        end
      end
      OP_REM_FIRST: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_shift = 1'b1;
          count_d  = count_m1;
        end
      end
      OP_REM_LAST: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_m1;
        end
      end
      OP_REM_AT: begin
        shift_base = q_req_i.position;
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else if (!pos_ok) begin
          status_d = ST_RANGE;
        end else begin
          do_shift = 1'b1;
          count_d  = count_m1;
        end
      end
      OP_GET_FIRST: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          word_d[WORD_W-1:0] = rd_word;
        end
      end
      OP_GET_LAST: begin
        rd_idx = count_m1[IDX_W-1:0];
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          word_d[WORD_W-1:0] = rd_word;
        end
      end
      OP_GET_AT: begin
        rd_idx = q_req_i.position;
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else if (!pos_ok) begin
          status_d = ST_RANGE;
        end else begin
          word_d[WORD_W-1:0] = rd_word;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      capacity_q  <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (exec) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q <= status_d;
      word_q   <= word_d;
    end
  end

  // Entries above the removed one move down a place; anything past the
  // count is stale and never read, so the whole upper part shifts.
  always_ff @(posedge clk_i) begin
    if (exec && do_append) begin
      entries_q[count_q[IDX_W-1:0]] <= q_req_i.value[WORD_W-1:0];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (exec && do_shift && (IDX_W'(i) >= shift_base)) begin
        entries_q[i] <= entries_q[i+1];
      end
    end
  end

  assign m_valid_o       = out_valid_q;
  assign m_status_o      = status_q;
  assign m_read_word_o   = word_q;
  assign m_entry_count_o = count_q;

endmodule
`default_nettype wire

// ===== sv/bounded_array_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The result of a request passes through the request queue and then the back end's
// output register. Throughput: one request per cycle while results are taken; the
// back end executes one request per clock while its output register is free, and
// the two-entry request queue and the output register absorb stalls.
// Reset (rst_ni low, asynchronous): the list is empty, capacity is 16, no result
// is pending. Entry storage is not cleared; entries are written before read.
// ----------------------------------------------------------------------------
// Bounded array list
// Ordered list of data words with append, remove (with shift) and get requests,
// built as a decoding front end, a request queue and an executing back end.
// ----------------------------------------------------------------------------
module bounded_array_list
  import bal_pkg::*;
#(
  parameter int unsigned WORD_W = WORD_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CAP_W-1:0]       cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // position[3:0], value[35:4]
  input  wire logic [FUNC_W-1:0]      s_axis_tuser,  // func[2:0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // read_word[31:0], entry_count[36:32]
  output logic [STATUS_W-1:0]         m_axis_tuser   // status[1:0]
);

  logic               q_valid, q_ready;
  req_t               q_req;
  status_e            res_status;
  logic [FIELD_W-1:0] res_word;
  logic [COUNT_W-1:0] res_count;

  bal_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_func_i     (s_axis_tuser),
    .s_position_i (s_axis_tdata[IDX_W-1:0]),
    .s_value_i    (s_axis_tdata[IDX_W +: FIELD_W]),
    .q_valid_o    (q_valid),
    .q_ready_i    (q_ready),
    .q_req_o      (q_req)
  );

  bal_back #(
    .WORD_W (WORD_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .q_ready_o       (q_ready),
    .q_req_i         (q_req),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_status_o      (res_status),
    .m_read_word_o   (res_word),
    .m_entry_count_o (res_count)
  );

  always_comb begin
    m_axis_tdata                    = '0;
    m_axis_tdata[FIELD_W-1:0]       = res_word;
    m_axis_tdata[FIELD_W +: COUNT_W] = res_count;
  end

  assign m_axis_tuser = res_status;

endmodule
`default_nettype wire

// ===== sv/bal_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list port checker
// Watches the result stream of the top level for consistent results.
// ----------------------------------------------------------------------------
module bal_props
  import bal_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [STATUS_W-1:0]    m_axis_tuser
);

  // A stalled result must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The count never passes the array size.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[FIELD_W +: COUNT_W] <= DEPTH_CNT)
    else $error("entry count above array size");

  // A failed request reads nothing.
  a_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_DONE) |-> m_axis_tdata[FIELD_W-1:0] == '0)
    else $error("failed request returned a word");

  // An empty status only comes from an empty list.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> m_axis_tdata[FIELD_W +: COUNT_W] == '0)
    else $error("empty status with entries present");

endmodule

bind bounded_array_list bal_props u_bal_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
